// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lpu8_pkg.sv =====
// Shared types and constants for the length-prefixed UTF-8 string decoder.
`timescale 1ns / 1ps

package lpu8_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    // Width that holds any varint contribution before it is cut to the length width.
    localparam int ADD_W = 40;
    localparam int UNIT_W = 16;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last;
        logic              empty_res;
    } lpu8_res_t;

endpackage

// ===== rtl/lpu8_core.sv =====
// Decode state and per-byte next-state logic of the string decoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpu8_core #(
    parameter int LENGTH_BITS = lpu8_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output lpu8_pkg::lpu8_res_t res
);
    import lpu8_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_LEAD,
        PH_CONT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] length_accum_reg, length_accum_next;
    logic [2:0]             varint_index_reg, varint_index_next;
    logic [LENGTH_BITS-1:0] chars_left_reg, chars_left_next;
    logic [UNIT_W-1:0]      partial_unit_reg, partial_unit_next;
    logic [1:0]             pending_reg, pending_next;

    logic [ADD_W-1:0]       add_wide;
    logic [LENGTH_BITS-1:0] acc_or;
    logic                   done;
    logic [LENGTH_BITS-1:0] chars_dec;
    logic [UNIT_W-1:0]      unit_emit;
    logic                   emit;
    logic [1:0]             pend_dec;

    always_comb
    begin
        phase_next        = phase_reg;
        length_accum_next = length_accum_reg;
        varint_index_next = varint_index_reg;
        chars_left_next   = chars_left_reg;
        partial_unit_next = partial_unit_reg;
        pending_next      = pending_reg;
        res_valid         = 1'b0;
        res               = '0;
        emit              = 1'b0;
        unit_emit         = '0;
        chars_dec         = chars_left_reg - LENGTH_BITS'(1);
        pend_dec          = pending_reg - 2'd1;

        // Varint contribution: 7 bits per byte, fifth byte whole at bit 28.
        if (varint_index_reg < 3'd4)
        begin
            add_wide = {{(ADD_W - 7){1'b0}}, in_byte[6:0]} << (7 * varint_index_reg);
            done     = !in_byte[7];
        end
        else
        begin
            add_wide = {{(ADD_W - 8){1'b0}}, in_byte} << 28;
            done     = 1'b1;
        end
        acc_or = length_accum_reg | add_wide[LENGTH_BITS-1:0];

        case (phase_reg)
            PH_LEAD:
            begin
                case (in_byte[7:4]) inside
                    [4'h0:4'h7]:
                    begin
                        emit      = 1'b1;
                        unit_emit = {8'h00, in_byte};
                    end
                    4'hC, 4'hD:
                    begin
                        partial_unit_next = {5'b0, in_byte[4:0], 6'b0};
                        pending_next      = 2'd1;
                        phase_next        = PH_CONT;
                    end
                    4'hE:
                    begin
                        partial_unit_next = {in_byte[3:0], 12'b0};
                        pending_next      = 2'd2;
                        phase_next        = PH_CONT;
                    end
                    default:
                    begin
                        // Stray continuation or 4-byte lead: dropped.
                    end
                endcase
            end
            PH_CONT:
            begin
                pending_next = pend_dec;
                if (pend_dec == 2'd0)
                begin
                    emit      = 1'b1;
                    unit_emit = partial_unit_reg | {10'b0, in_byte[5:0]};
                end
                else
                begin
                    partial_unit_next = partial_unit_reg | {4'b0, in_byte[5:0], 6'b0};
                end
            end
            default:
            begin
                length_accum_next = acc_or;
                if (!done)
                begin
                    varint_index_next = varint_index_reg + 3'd1;
                end
                else
                begin
                    length_accum_next = '0;
                    varint_index_next = '0;
                    partial_unit_next = '0;
                    pending_next      = '0;
                    if (acc_or <= LENGTH_BITS'(1))
                    begin
                        chars_left_next = '0;
                        phase_next      = PH_LEN;
                        res_valid       = 1'b1;
                        res.code_unit   = '0;
                        res.last        = 1'b1;
                        res.empty_res   = 1'b1;
                    end
                    else
                    begin
                        chars_left_next = acc_or - LENGTH_BITS'(1);
                        phase_next      = PH_LEAD;
                    end
                end
            end
        endcase

        if (emit)
        begin
            chars_left_next   = chars_dec;
            partial_unit_next = '0;
            pending_next      = '0;
            phase_next        = (chars_dec == '0) ? PH_LEN : PH_LEAD;
            res_valid         = 1'b1;
            res.code_unit     = unit_emit;
            res.last          = (chars_dec == '0);
            res.empty_res     = 1'b0;
        end

        if (!accept)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN;
            length_accum_reg <= '0;
            varint_index_reg <= '0;
            chars_left_reg   <= '0;
            partial_unit_reg <= '0;
            pending_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            length_accum_reg <= length_accum_next;
            varint_index_reg <= varint_index_next;
            chars_left_reg   <= chars_left_next;
            partial_unit_reg <= partial_unit_next;
            pending_reg      <= pending_next;
        end
    end

    `ASSERT_IMPL(a_cont_pending, phase_reg == PH_CONT, pending_reg != 2'd0)
    `ASSERT_IMPL(a_chars_in_string, phase_reg != PH_LEN, chars_left_reg != '0)
    `ASSERT_IMPL(a_empty_is_last, res_valid && res.empty_res,
                 res.last && (res.code_unit == '0) && (phase_next == PH_LEN))

endmodule

// ===== rtl/lpu8_out_buf.sv =====
// Two-entry result buffer between the decode logic and the result channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpu8_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpu8_pkg::lpu8_res_t push_data,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lpu8_pkg::lpu8_res_t pop_data
);
    import lpu8_pkg::*;

    lpu8_res_t  mem_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_ptr;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;
    assign wr_ptr    = rd_ptr_reg ^ count_reg[0];

    always_comb
    begin
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr] <= push_data;
        end
    end

    `ASSERT_IMPL(a_count_range, 1'b1, count_reg != 2'd3)
    `ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 2'd1)
    `ASSERT_NEXT(a_last_pop_drains, pop && !push && (count_reg == 2'd1), !pop_valid)

endmodule

// ===== rtl/length_prefixed_utf8_string_decoder.sv =====
// Top level of the length-prefixed UTF-8 string decoder.
`timescale 1ns / 1ps

// Decodes a byte stream of strings, each opened by a little-endian base-128
// varint length of 1 to 5 bytes (the fifth byte is taken whole at bit 28;
// length bits above LENGTH_BITS are dropped). The length counts a
// terminator, so 0 or 1 gives a single empty result (code_unit 0, last and
// empty_res high). Otherwise length-1 characters follow in 1, 2 or 3 byte
// UTF-8; each gives one 16-bit code unit, last marking the final one. Lead
// bytes 0x80-0xBF and 0xF0-0xFF are dropped without using up a character,
// and continuation bytes are not checked. Rate: one byte request per cycle
// while the result buffer is not full; the result of a byte is written into
// the result buffer as the byte is taken, and the decode state updates once
// per byte taken. A two-entry result buffer lets byte requests keep flowing
// while a result waits. str_ready falls only when both buffer entries hold
// untaken results. No clearing pass after reset.
module length_prefixed_utf8_string_decoder #(
    parameter int LENGTH_BITS = lpu8_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        str_valid,
    output logic        str_ready,
    input  logic [7:0]  in_byte,
    output logic        unit_valid,
    input  logic        unit_ready,
    output logic [15:0] code_unit,
    output logic        last,
    output logic        empty_res
);
    import lpu8_pkg::*;

    logic      accept;
    logic      res_valid;
    lpu8_res_t res;
    lpu8_res_t head;
    logic      buf_full;

    // A byte request is taken whenever the buffer has a free entry, so any
    // result it causes always has room.
    assign str_ready = !buf_full;
    assign accept    = str_valid && str_ready;

    lpu8_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .res_valid(res_valid),
        .res      (res)
    );

    lpu8_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_data(res),
        .full     (buf_full),
        .pop_valid(unit_valid),
        .pop_ready(unit_ready),
        .pop_data (head)
    );

    assign code_unit = head.code_unit;
    assign last      = head.last;
    assign empty_res = head.empty_res;

endmodule
